>>> rtl/stc_pkg.sv
package stc_pkg;

  localparam int TP   = 10;
  localparam int LAST = TP - 1;
  localparam int IW   = $clog2(TP);
  localparam int SPW  = 21;
  localparam int NUMW = SPW + 8;

  localparam logic [15:0] SPEED_MIN = 16'd80;
  localparam logic [7:0]  CONC_INVALID = 8'd255;

  typedef logic [IW-1:0] idx_t;

  localparam logic signed [7:0] TEMP_BP [TP] = '{
    -8'sd11, 8'sd0, 8'sd10, 8'sd20, 8'sd30, 8'sd40, 8'sd50, 8'sd60, 8'sd70, 8'sd80
  };

  localparam logic [7:0] CONC_PT [TP] = '{
    8'd0, 8'd40, 8'd80, 8'd100, 8'd112, 8'd120, 8'd128, 8'd140, 8'd180, 8'd220
  };

  // speed points in 0.01 m/s
  localparam logic [17:0] SPEED_TAB [TP][TP] = '{
    '{18'd140700, 18'd144043, 18'd148051, 18'd149969, 18'd151191,
      18'd151892, 18'd152590, 18'd153528, 18'd157607, 18'd161332},
    '{18'd140700, 18'd144043, 18'd148051, 18'd149969, 18'd151191,
      18'd151892, 18'd152590, 18'd153528, 18'd157607, 18'd161332},
    '{18'd140700, 18'd144043, 18'd148051, 18'd149969, 18'd151191,
      18'd151892, 18'd152590, 18'd153528, 18'd157607, 18'd161332},
    '{18'd140700, 18'd144043, 18'd148051, 18'd149969, 18'd151191,
      18'd151892, 18'd152590, 18'd153528, 18'd157607, 18'd161332},
    '{18'd140700, 18'd144043, 18'd148051, 18'd149969, 18'd151191,
      18'd151892, 18'd152590, 18'd153528, 18'd157607, 18'd161332},
    '{18'd140700, 18'd144043, 18'd148051, 18'd149969, 18'd151191,
      18'd151892, 18'd152590, 18'd153528, 18'd157607, 18'd161332},
    '{18'd140700, 18'd144043, 18'd148051, 18'd149969, 18'd151191,
      18'd151892, 18'd152590, 18'd153528, 18'd157607, 18'd161332},
    '{18'd140700, 18'd144043, 18'd148051, 18'd149969, 18'd151191,
      18'd151892, 18'd152590, 18'd153528, 18'd157607, 18'd161332},
    '{18'd140700, 18'd144043, 18'd148051, 18'd149969, 18'd151191,
      18'd151892, 18'd152590, 18'd153528, 18'd157607, 18'd161332},
    '{18'd140700, 18'd144043, 18'd148051, 18'd149969, 18'd151191,
      18'd151892, 18'd152590, 18'd153528, 18'd157607, 18'd161332}
  };

  typedef struct packed {
    logic       invalid;
    logic       single;
    logic       low_a;
    logic       high_a;
    logic       empty_a;
    logic       low_b;
    logic       high_b;
    logic       empty_b;
    logic [7:0] base_a;
    logic [7:0] base_b;
    logic [7:0] dt;
    logic [7:0] dx;
  } front_side_t;

  typedef struct packed {
    logic       fixed;
    logic [7:0] fixed_val;
    logic [7:0] c1;
    logic       neg;
  } mix_side_t;

  // table speed in 1/400 m/s
  function automatic logic [SPW-1:0] tab4(idx_t r, idx_t c);
    return {1'b0, SPEED_TAB[r][c], 2'b00};
  endfunction

endpackage

>>> rtl/stc_div.sv
module stc_div
  import stc_pkg::*;
#(
  parameter int NW = 29,
  parameter int DW = 21,
  parameter int QW = 8,
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_q,
  output logic [SW-1:0] out_side
);

  localparam int WW = (NW > DW + QW) ? NW : DW + QW;

  logic          v_r    [QW];
  logic [NW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] q_r    [QW];
  logic [SW-1:0] side_r [QW];

  // one quotient bit per stage, MSB first
  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic          v_in;
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] q_in;
    logic [SW-1:0] side_in;
    logic [WW-1:0] shd;
    logic [WW-1:0] rem_w;
    logic          take;
    logic [NW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;

    if (j == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_num;
      assign den_in  = in_den;
      assign q_in    = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign den_in  = den_r[j-1];
      assign q_in    = q_r[j-1];
      assign side_in = side_r[j-1];
    end

    assign shd     = WW'(den_in) << (QW - 1 - j);
    assign rem_w   = WW'(rem_in);
    assign take    = rem_w >= shd;
    assign rem_nxt = take ? NW'(rem_w - shd) : rem_in;
    assign q_nxt   = take ? (q_in | (QW'(1) << (QW - 1 - j))) : q_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        den_r[j]  <= den_in;
        q_r[j]    <= q_nxt;
        side_r[j] <= side_in;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_q     = q_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

>>> rtl/stc_front.sv
module stc_front
  import stc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [15:0]       in_speed,
  input  logic signed [7:0] in_temperature,
  output logic              out_valid,
  output logic [NUMW-1:0]   out_num_a,
  output logic [SPW-1:0]    out_den_a,
  output logic [NUMW-1:0]   out_num_b,
  output logic [SPW-1:0]    out_den_b,
  output front_side_t       out_side
);

  function automatic idx_t seg_search(idx_t r, logic [SPW-1:0] s);
    idx_t p;
    p = '0;
    for (int i = 0; i < LAST; i++) begin
      if (tab4(r, IW'(i)) <= s) p = IW'(i);
    end
    return p;
  endfunction

  // stage 1: temperature bracket
  logic              single_nxt;
  idx_t              ra_nxt;
  idx_t              rb_nxt;
  logic [7:0]        dt_nxt;
  logic [7:0]        dx_nxt;
  idx_t              tp;

  always_comb begin
    single_nxt = 1'b1;
    ra_nxt     = '0;
    dt_nxt     = '0;
    dx_nxt     = '0;
    tp         = '0;
    if (in_temperature <= TEMP_BP[0]) begin
      ra_nxt = '0;
    end else if (in_temperature >= TEMP_BP[LAST]) begin
      ra_nxt = IW'(LAST);
    end else begin
      for (int i = 0; i < LAST; i++) begin
        if (TEMP_BP[i] <= in_temperature) tp = IW'(i);
      end
      ra_nxt = tp;
      if (TEMP_BP[tp] != in_temperature) begin
        single_nxt = 1'b0;
        dt_nxt = 8'({in_temperature[7], in_temperature} -
                     {TEMP_BP[tp][7], TEMP_BP[tp]});
        dx_nxt = 8'({TEMP_BP[tp + IW'(1)][7], TEMP_BP[tp + IW'(1)]} -
                     {TEMP_BP[tp][7], TEMP_BP[tp]});
      end
    end
    rb_nxt = single_nxt ? ra_nxt : ra_nxt + IW'(1);
  end

  logic           v1_r;
  logic [SPW-1:0] s1_r;
  logic           inv1_r;
  logic           single1_r;
  idx_t           ra1_r;
  idx_t           rb1_r;
  logic [7:0]     dt1_r;
  logic [7:0]     dx1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r      <= SPW'(in_speed) * SPW'(25);
      inv1_r    <= in_speed < SPEED_MIN;
      single1_r <= single_nxt;
      ra1_r     <= ra_nxt;
      rb1_r     <= rb_nxt;
      dt1_r     <= dt_nxt;
      dx1_r     <= dx_nxt;
    end
  end

  // stage 2: speed search in both rows
  logic           v2_r;
  logic [SPW-1:0] s2_r;
  logic           inv2_r;
  logic           single2_r;
  idx_t           ra2_r;
  idx_t           rb2_r;
  idx_t           pa2_r;
  idx_t           pb2_r;
  logic           low_a2_r;
  logic           high_a2_r;
  logic           low_b2_r;
  logic           high_b2_r;
  logic [7:0]     dt2_r;
  logic [7:0]     dx2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r      <= s1_r;
      inv2_r    <= inv1_r;
      single2_r <= single1_r;
      ra2_r     <= ra1_r;
      rb2_r     <= rb1_r;
      pa2_r     <= seg_search(ra1_r, s1_r);
      pb2_r     <= seg_search(rb1_r, s1_r);
      low_a2_r  <= s1_r <= tab4(ra1_r, '0);
      high_a2_r <= s1_r >= tab4(ra1_r, IW'(LAST));
      low_b2_r  <= s1_r <= tab4(rb1_r, '0);
      high_b2_r <= s1_r >= tab4(rb1_r, IW'(LAST));
      dt2_r     <= dt1_r;
      dx2_r     <= dx1_r;
    end
  end

  // stage 3: segment offset, width and slope
  logic           v3_r;
  logic [SPW-1:0] diff_a3_r;
  logic [SPW-1:0] diff_b3_r;
  logic [SPW-1:0] den_a3_r;
  logic [SPW-1:0] den_b3_r;
  logic [7:0]     dc_a3_r;
  logic [7:0]     dc_b3_r;
  front_side_t    side3_r;
  front_side_t    side3_nxt;

  always_comb begin
    side3_nxt         = '0;
    side3_nxt.invalid = inv2_r;
    side3_nxt.single  = single2_r;
    side3_nxt.low_a   = low_a2_r;
    side3_nxt.high_a  = high_a2_r;
    side3_nxt.empty_a = tab4(ra2_r, pa2_r + IW'(1)) <= tab4(ra2_r, pa2_r);
    side3_nxt.low_b   = low_b2_r;
    side3_nxt.high_b  = high_b2_r;
    side3_nxt.empty_b = tab4(rb2_r, pb2_r + IW'(1)) <= tab4(rb2_r, pb2_r);
    side3_nxt.base_a  = CONC_PT[pa2_r];
    side3_nxt.base_b  = CONC_PT[pb2_r];
    side3_nxt.dt      = dt2_r;
    side3_nxt.dx      = dx2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_a3_r <= s2_r - tab4(ra2_r, pa2_r);
      diff_b3_r <= s2_r - tab4(rb2_r, pb2_r);
      den_a3_r  <= tab4(ra2_r, pa2_r + IW'(1)) - tab4(ra2_r, pa2_r);
      den_b3_r  <= tab4(rb2_r, pb2_r + IW'(1)) - tab4(rb2_r, pb2_r);
      dc_a3_r   <= CONC_PT[pa2_r + IW'(1)] - CONC_PT[pa2_r];
      dc_b3_r   <= CONC_PT[pb2_r + IW'(1)] - CONC_PT[pb2_r];
      side3_r   <= side3_nxt;
    end
  end

  // stage 4: numerators
  logic            v4_r;
  logic [NUMW-1:0] num_a4_r;
  logic [NUMW-1:0] num_b4_r;
  logic [SPW-1:0]  den_a4_r;
  logic [SPW-1:0]  den_b4_r;
  front_side_t     side4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_a4_r <= NUMW'(diff_a3_r) * NUMW'(dc_a3_r);
      num_b4_r <= NUMW'(diff_b3_r) * NUMW'(dc_b3_r);
      den_a4_r <= den_a3_r;
      den_b4_r <= den_b3_r;
      side4_r  <= side3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_num_a = num_a4_r;
  assign out_den_a = den_a4_r;
  assign out_num_b = num_b4_r;
  assign out_den_b = den_b4_r;
  assign out_side  = side4_r;

endmodule

>>> rtl/stc_mix.sv
module stc_mix
  import stc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_valid,
  input  logic [7:0]  in_q_a,
  input  logic [7:0]  in_q_b,
  input  front_side_t in_side,
  output logic        out_valid,
  output logic [15:0] out_num,
  output logic [7:0]  out_den,
  output mix_side_t   out_side
);

  function automatic logic [7:0] row_res(logic low, logic high, logic empty,
                                         logic [7:0] base, logic [7:0] q);
    logic [8:0] sum;
    sum = {1'b0, base} + {1'b0, q};
    if (low) return CONC_PT[0];
    if (high) return CONC_PT[LAST];
    if (empty) return base;
    return sum[8] ? 8'd255 : sum[7:0];
  endfunction

  // stage 1: row results and corner cases
  logic [7:0] c1_nxt;
  logic [7:0] c2_nxt;
  logic       fixed_nxt;
  logic [7:0] fval_nxt;

  always_comb begin
    c1_nxt = row_res(in_side.low_a, in_side.high_a, in_side.empty_a, in_side.base_a, in_q_a);
    c2_nxt = row_res(in_side.low_b, in_side.high_b, in_side.empty_b, in_side.base_b, in_q_b);
    fixed_nxt = 1'b1;
    if (in_side.invalid) begin
      fval_nxt = CONC_INVALID;
    end else if (in_side.single) begin
      fval_nxt = c1_nxt;
    end else if (in_side.low_a || in_side.low_b) begin
      fval_nxt = CONC_PT[0];
    end else if (in_side.high_a || in_side.high_b) begin
      fval_nxt = CONC_PT[LAST];
    end else begin
      fixed_nxt = 1'b0;
      fval_nxt  = c1_nxt;
    end
  end

  logic       v1_r;
  logic [7:0] c1_r;
  logic [7:0] c2_r;
  logic       fixed1_r;
  logic [7:0] fval1_r;
  logic [7:0] dt1_r;
  logic [7:0] dx1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r     <= c1_nxt;
      c2_r     <= c2_nxt;
      fixed1_r <= fixed_nxt;
      fval1_r  <= fval_nxt;
      dt1_r    <= in_side.dt;
      dx1_r    <= in_side.dx;
    end
  end

  // stage 2: temperature numerator as sign and magnitude
  logic [8:0] d;
  logic [7:0] mag;

  assign d   = {1'b0, c2_r} - {1'b0, c1_r};
  assign mag = d[8] ? 8'(-d) : d[7:0];

  logic        v2_r;
  logic [15:0] num2_r;
  logic [7:0]  den2_r;
  mix_side_t   side2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num2_r            <= 16'(dt1_r) * 16'(mag);
      den2_r            <= dx1_r;
      side2_r.fixed     <= fixed1_r;
      side2_r.fixed_val <= fval1_r;
      side2_r.c1        <= c1_r;
      side2_r.neg       <= d[8];
    end
  end

  assign out_valid = v2_r;
  assign out_num   = num2_r;
  assign out_den   = den2_r;
  assign out_side  = side2_r;

endmodule

>>> rtl/speed_temp_to_concentration.sv
// Concentration from sound speed (unsigned Q12.4 m/s) and temperature (signed
// degrees C) by bilinear lookup in fixed ROM tables; result in 0.25 % units,
// 255 when the speed is below 5 m/s. Fully pipelined: one transaction per
// cycle sustained while not stalled. Data passes through the bracket search
// and multiply front end (4 stages), the bit-per-stage speed dividers (8),
// the row blend stages (2), the temperature divider (8) and the output
// register. The whole pipeline holds while out_ready is low and out_valid is high.
module speed_temp_to_concentration
  import stc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       in_speed,
  input  logic signed [7:0] in_temperature,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_concentration
);

  localparam int FSW = $bits(front_side_t);
  localparam int MSW = $bits(mix_side_t);

  logic en;
  logic out_valid_r;
  logic [7:0] out_conc_r;

  assign en = !out_valid_r || out_ready;
  assign in_ready = en;

  logic            fr_valid;
  logic [NUMW-1:0] fr_num_a;
  logic [SPW-1:0]  fr_den_a;
  logic [NUMW-1:0] fr_num_b;
  logic [SPW-1:0]  fr_den_b;
  front_side_t     fr_side;

  stc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .en             (en),
    .in_valid       (in_valid),
    .in_speed       (in_speed),
    .in_temperature (in_temperature),
    .out_valid      (fr_valid),
    .out_num_a      (fr_num_a),
    .out_den_a      (fr_den_a),
    .out_num_b      (fr_num_b),
    .out_den_b      (fr_den_b),
    .out_side       (fr_side)
  );

  logic           da_valid;
  logic [7:0]     da_q;
  logic [FSW-1:0] da_side;
  logic           db_valid;
  logic [7:0]     db_q;
  logic [0:0]     db_side;

  stc_div #(.NW(NUMW), .DW(SPW), .QW(8), .SW(FSW)) u_div_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_num    (fr_num_a),
    .in_den    (fr_den_a),
    .in_side   (fr_side),
    .out_valid (da_valid),
    .out_q     (da_q),
    .out_side  (da_side)
  );

  stc_div #(.NW(NUMW), .DW(SPW), .QW(8), .SW(1)) u_div_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_num    (fr_num_b),
    .in_den    (fr_den_b),
    .in_side   (fr_valid),
    .out_valid (db_valid),
    .out_q     (db_q),
    .out_side  (db_side)
  );

  logic        mx_valid;
  logic [15:0] mx_num;
  logic [7:0]  mx_den;
  mix_side_t   mx_side;

  stc_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (da_valid && db_valid && db_side[0]),
    .in_q_a    (da_q),
    .in_q_b    (db_q),
    .in_side   (front_side_t'(da_side)),
    .out_valid (mx_valid),
    .out_num   (mx_num),
    .out_den   (mx_den),
    .out_side  (mx_side)
  );

  logic           dt_valid;
  logic [7:0]     dt_q;
  logic [MSW-1:0] dt_side;
  mix_side_t      fin;

  stc_div #(.NW(16), .DW(8), .QW(8), .SW(MSW)) u_div_t (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (mx_valid),
    .in_num    (mx_num),
    .in_den    (mx_den),
    .in_side   (mx_side),
    .out_valid (dt_valid),
    .out_q     (dt_q),
    .out_side  (dt_side)
  );

  assign fin = mix_side_t'(dt_side);

  logic signed [9:0] blend;
  logic [7:0]        conc_nxt;

  always_comb begin
    blend = fin.neg ? $signed({2'b00, fin.c1}) - $signed({2'b00, dt_q})
                    : $signed({2'b00, fin.c1}) + $signed({2'b00, dt_q});
    if (fin.fixed) begin
      conc_nxt = fin.fixed_val;
    end else if (blend < 0) begin
      conc_nxt = 8'd0;
    end else if (blend > 10'sd255) begin
      conc_nxt = 8'd255;
    end else begin
      conc_nxt = blend[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_conc_r <= conc_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_concentration = out_conc_r;

endmodule
